[hw/rtl/fse_pkg.sv]
// fse_pkg: shared types and constants for the floor-sum block.
// Used by fse_alu and floor_sum_euclidean; depends on nothing.
package fse_pkg;

  localparam int unsigned DW    = 64;
  localparam int unsigned CNT_W = $clog2(DW);

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TRI,
    S_NA,
    S_NA_MUL,
    S_NB,
    S_NB_MUL,
    S_LA,
    S_LA_TRI,
    S_LA_MUL,
    S_LB,
    S_LB_MUL,
    S_TOP,
    S_TOP_DIV,
    S_DONE
  } fse_state_t;

endpackage

[hw/rtl/fse_alu.sv]
// fse_alu: bit-serial shared unit, 64-bit multiply (mod 2^64) or
// unsigned divide, one bit per cycle. Depends on fse_pkg.
module fse_alu (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fse_pkg::alu_req_t         req,
  input  logic [fse_pkg::DW-1:0]    x,
  input  logic [fse_pkg::DW-1:0]    y,
  output logic                      done,
  output logic [fse_pkg::DW-1:0]    res,
  output logic [fse_pkg::DW-1:0]    rem
);
  import fse_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  alu_op_t          op_r;
  logic [DW-1:0]    x_r;
  logic [DW-1:0]    y_r;
  logic [DW-1:0]    acc_r;

  logic [DW-1:0]    trial;
  logic             ge;

  // divide: acc holds the partial remainder, x shifts out dividend bits
  // and shifts in quotient bits
  assign trial = {acc_r[DW-2:0], x_r[DW-1]};
  assign ge    = (trial >= y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        op_r   <= req.op;
        x_r    <= x;
        y_r    <= y;
        acc_r  <= '0;
      end else if (busy_r) begin
        if (op_r == ALU_MUL) begin
          acc_r <= acc_r + (y_r[0] ? x_r : '0);
          x_r   <= {x_r[DW-2:0], 1'b0};
          y_r   <= {1'b0, y_r[DW-1:1]};
        end else begin
          acc_r <= ge ? (trial - y_r) : trial;
          x_r   <= {x_r[DW-2:0], ge};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = (op_r == ALU_MUL) ? acc_r : x_r;
  assign rem  = acc_r;

endmodule

[hw/rtl/floor_sum_euclidean.sv]
// floor_sum_euclidean: top level, sequencer for the Euclidean floor-sum
// descent around one shared serial multiply/divide unit (fse_alu, fse_pkg).
//
//  channel | ports                                          | direction
//  input   | start, busy, in_term_count, in_divisor,       | in (busy out)
//          | in_slope, in_offset                            |
//  result  | out_valid, out_floor_total                     | out
//
// Each multiply or divide is issued once to the serial unit, which then
// works it bit-serially; a skipped step does not start the unit.
// A zero divisor shows its result in the cycle after the accept.
// Reset is synchronous, active low, and returns the sequencer to idle.
// The result is shown for one cycle with out_valid; it cannot be stalled.
module floor_sum_euclidean (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_term_count,
  input  logic [31:0] in_divisor,
  input  logic [63:0] in_slope,
  input  logic [63:0] in_offset,
  output logic        out_valid,
  output logic [63:0] out_floor_total
);
  import fse_pkg::*;

  fse_state_t    st_r, st_nxt;
  logic          wait_r, wait_nxt;
  logic [DW-1:0] n_r, n_nxt;
  logic [DW-1:0] m_r, m_nxt;
  logic [DW-1:0] a_r, a_nxt;
  logic [DW-1:0] b_r, b_nxt;
  logic [DW-1:0] tot_r, tot_nxt;
  logic [DW-1:0] tri_r, tri_nxt;
  logic [DW-1:0] q_r, q_nxt;

  alu_req_t      alu_req;
  logic [DW-1:0] alu_x, alu_y;
  logic          alu_done;
  logic [DW-1:0] alu_res, alu_rem;
  logic [DW-1:0] top;

  fse_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .x     (alu_x),
    .y     (alu_y),
    .done  (alu_done),
    .res   (alu_res),
    .rem   (alu_rem)
  );

  assign top = alu_res + b_r;

  always_comb begin
    st_nxt   = st_r;
    wait_nxt = wait_r;
    n_nxt    = n_r;
    m_nxt    = m_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    tot_nxt  = tot_r;
    tri_nxt  = tri_r;
    q_nxt    = q_r;
    alu_req.start = 1'b0;
    alu_req.op    = ALU_MUL;
    alu_x    = n_r;
    alu_y    = n_r - 1'b1;

    case (st_r)
      S_IDLE: begin
        if (start) begin
          n_nxt   = {32'd0, in_term_count};
          m_nxt   = {32'd0, in_divisor};
          a_nxt   = in_slope;
          b_nxt   = in_offset;
          tot_nxt = '0;
          st_nxt  = (in_divisor == 32'd0) ? S_DONE : S_TRI;
        end
      end
      S_TRI, S_LA_TRI: begin
        alu_req.start = !wait_r;
        wait_nxt = 1'b1;
        if (alu_done) begin
          wait_nxt = 1'b0;
          tri_nxt  = {1'b0, alu_res[DW-1:1]};
          st_nxt   = (st_r == S_TRI) ? S_NA : S_LA_MUL;
        end
      end
      S_NA, S_NB: begin
        // negative value: divide its magnitude, quotient rounds up
        alu_req.op = ALU_DIV;
        alu_x = '0 - ((st_r == S_NA) ? a_r : b_r);
        alu_y = m_r;
        if (!((st_r == S_NA) ? a_r[DW-1] : b_r[DW-1])) begin
          st_nxt = (st_r == S_NA) ? S_NB : S_LA;
        end else begin
          alu_req.start = !wait_r;
          wait_nxt = 1'b1;
          if (alu_done) begin
            wait_nxt = 1'b0;
            q_nxt = alu_res + ((alu_rem != '0) ? DW'(1) : DW'(0));
            if (st_r == S_NA) begin
              a_nxt  = (alu_rem != '0) ? (m_r - alu_rem) : '0;
              st_nxt = S_NA_MUL;
            end else begin
              b_nxt  = (alu_rem != '0) ? (m_r - alu_rem) : '0;
              st_nxt = S_NB_MUL;
            end
          end
        end
      end
      S_NA_MUL, S_NB_MUL, S_LA_MUL, S_LB_MUL: begin
        alu_req.start = !wait_r;
        wait_nxt = 1'b1;
        alu_x = (st_r == S_NA_MUL || st_r == S_LA_MUL) ? tri_r : n_r;
        alu_y = q_r;
        if (alu_done) begin
          wait_nxt = 1'b0;
          case (st_r)
            S_NA_MUL: begin
              tot_nxt = tot_r - alu_res;
              st_nxt  = S_NB;
            end
            S_NB_MUL: begin
              tot_nxt = tot_r - alu_res;
              st_nxt  = S_LA;
            end
            S_LA_MUL: begin
              tot_nxt = tot_r + alu_res;
              st_nxt  = S_LB;
            end
            default: begin
              tot_nxt = tot_r + alu_res;
              st_nxt  = S_TOP;
            end
          endcase
        end
      end
      S_LA, S_LB: begin
        alu_req.op = ALU_DIV;
        alu_x = (st_r == S_LA) ? a_r : b_r;
        alu_y = m_r;
        if (alu_x < m_r) begin
          st_nxt = (st_r == S_LA) ? S_LB : S_TOP;
        end else begin
          alu_req.start = !wait_r;
          wait_nxt = 1'b1;
          if (alu_done) begin
            wait_nxt = 1'b0;
            q_nxt = alu_res;
            if (st_r == S_LA) begin
              a_nxt  = alu_rem;
              st_nxt = S_LA_TRI;
            end else begin
              b_nxt  = alu_rem;
              st_nxt = S_LB_MUL;
            end
          end
        end
      end
      S_TOP: begin
        alu_req.start = !wait_r;
        wait_nxt = 1'b1;
        alu_x = a_r;
        alu_y = n_r;
        if (alu_done) begin
          wait_nxt = 1'b0;
          q_nxt    = top;
          st_nxt   = (top < m_r) ? S_DONE : S_TOP_DIV;
        end
      end
      S_TOP_DIV: begin
        // new count and remainder, then swap slope and modulus
        alu_req.op    = ALU_DIV;
        alu_req.start = !wait_r;
        wait_nxt = 1'b1;
        alu_x = q_r;
        alu_y = m_r;
        if (alu_done) begin
          wait_nxt = 1'b0;
          n_nxt    = alu_res;
          b_nxt    = alu_rem;
          a_nxt    = m_r;
          m_nxt    = a_r;
          st_nxt   = S_LA;
        end
      end
      S_DONE: begin
        st_nxt = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      wait_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      wait_r <= wait_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    m_r   <= m_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    tot_r <= tot_nxt;
    tri_r <= tri_nxt;
    q_r   <= q_nxt;
  end

  assign busy            = (st_r != S_IDLE);
  assign out_valid       = (st_r == S_DONE);
  assign out_floor_total = tot_r;

endmodule

[hw/rtl/fse_checker.sv]
// fse_checker: port-level assertions for floor_sum_euclidean, bound to
// the top level below. Depends only on the top level's ports.
module fse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [31:0] in_divisor,
  input logic        out_valid,
  input logic [63:0] out_floor_total
);

  // a result strobe lasts exactly one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid held more than one cycle");

  // an accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // the result closes the transaction
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("busy still high after result");

  // no result without a transaction in flight
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result while idle");

  // zero divisor answers zero right away
  a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_divisor == 32'd0) |=>
      (out_valid && out_floor_total == 64'd0))
    else $error("zero divisor result wrong");

endmodule

bind floor_sum_euclidean fse_checker u_fse_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_divisor      (in_divisor),
  .out_valid       (out_valid),
  .out_floor_total (out_floor_total)
);
